// File: hdl/serial_tagged_packet_fifo_defines.svh
// assertion macros used by the checker of the packet descriptor queue
// no dependencies
`ifndef SERIAL_TAGGED_PACKET_FIFO_DEFINES_SVH
`define SERIAL_TAGGED_PACKET_FIFO_DEFINES_SVH

// implication on the same edge, off during reset
`define STPF_ASSERT_SAME(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("stpf assertion failed");

// implication on the next edge, off during reset
`define STPF_ASSERT_NEXT(lbl, clk, pre, post, rst_n) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("stpf assertion failed");

// implication on the next edge, checked during reset too
`define STPF_ASSERT_NEXT_ALWAYS(lbl, clk, pre, post) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("stpf assertion failed");

`endif

// File: hdl/stpf_pkg.sv
// types, codes and constants of the packet descriptor queue
// no dependencies
package stpf_pkg;

  localparam int QUEUE_DEPTH_DEF    = 64;
  localparam int ENTRY_OVERHEAD_DEF = 96;

  localparam int IN_DATA_W  = 136;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 240;
  localparam int OUT_USER_W = 2;

  localparam int RES_FIFO_DEPTH = 4;
  localparam int RES_PTR_W      = $clog2(RES_FIFO_DEPTH);
  localparam int RES_CNT_W      = $clog2(RES_FIFO_DEPTH + 1);

  typedef enum logic [2:0] {
    OP_PUT    = 3'd0,
    OP_MARKER = 3'd1,
    OP_GET    = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_ABORT  = 3'd4,
    OP_START  = 3'd5
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_PUT  = 2'd0,
    KIND_GET  = 2'd1,
    KIND_CTRL = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ABORTED = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef struct packed {
    opcode_t     opcode;
    logic [63:0] descriptor;
    logic [23:0] packet_size;
    logic [31:0] packet_duration;
    logic [7:0]  stream_id;
    logic        wait_if_empty;
  } req_t;

  typedef struct packed {
    logic [63:0] handle;
    logic [23:0] size;
    logic [31:0] duration;
    logic [7:0]  stream;
    logic        marker;
    logic [31:0] epoch;
  } entry_t;

  typedef struct packed {
    kind_t       kind;
    status_t     status;
    logic [63:0] descriptor;
    logic [23:0] size;
    logic [31:0] duration;
    logic [7:0]  stream;
    logic        is_flush;
    logic [31:0] serial;
    logic [6:0]  count;
    logic [30:0] bytes;
    logic [37:0] qtime;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0] num;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

// File: hdl/serial_tagged_packet_fifo.sv
// Packet descriptor queue with flush serials, top level.
// Depends on stpf_pkg, stpf_core and stpf_result_fifo.
//
// The in_ channel carries one operation per item: in_tuser holds the opcode
// (put, put flush marker, get, clear, abort, start), in_tdata the packet
// descriptor fields. The out_ channel returns one or two result items per
// operation; out_tlast marks the final result of an operation, out_tuser its
// reply kind. A get on an empty queue with wait set gives no result until a
// later put or start delivers it or an abort cancels it.
// Every operation is decided in the cycle it is accepted against the
// registered head entry of the descriptor store, so one item per cycle is
// accepted while in_tready is high; results reach out_ through a registered
// four-entry result queue, which decouples the two sides: in_tready drops
// when fewer than two free result slots remain, so a stalled receiver backs
// up the input once three or four results are pending. After reset the queue
// is empty and aborted until a start operation; no clearing pass is needed.
module serial_tagged_packet_fifo
  import stpf_pkg::*;
#(
  parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF,
  parameter int ENTRY_OVERHEAD = ENTRY_OVERHEAD_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // descriptor, packet_size, packet_duration, stream_id, wait_if_empty
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // opcode
  input  logic [IN_USER_W-1:0]  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // status, out_descriptor, out_size, out_duration, out_stream, out_is_flush,
  // out_serial, queued_count, queued_bytes, queued_time
  output logic [OUT_DATA_W-1:0] out_tdata,
  // reply_kind
  output logic [OUT_USER_W-1:0] out_tuser,
  output logic                  out_tlast
);

  req_t    req;
  push_t   push;
  result_t res;
  logic    accept;

  assign accept = in_tvalid && in_tready;

  always_comb begin
    req.opcode          = opcode_t'(in_tuser);
    req.descriptor      = in_tdata[63:0];
    req.packet_size     = in_tdata[87:64];
    req.packet_duration = in_tdata[119:88];
    req.stream_id       = in_tdata[127:120];
    req.wait_if_empty   = in_tdata[128];
  end

  stpf_core #(
    .QUEUE_DEPTH    (QUEUE_DEPTH),
    .ENTRY_OVERHEAD (ENTRY_OVERHEAD)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .req    (req),
    .push   (push)
  );

  stpf_result_fifo u_res (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {1'b0, res.qtime, res.bytes, res.count, res.serial, res.is_flush,
                      res.stream, res.duration, res.size, res.descriptor, res.status};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

endmodule

// File: hdl/stpf_result_fifo.sv
// small result queue between the operation logic and the output channel
// depends on stpf_pkg
module stpf_result_fifo
  import stpf_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  push_t   push,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  result_t              mem_r [RES_FIFO_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [RES_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [RES_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 pop;
  logic [RES_PTR_W-1:0] wr_ptr_p1;

  assign in_ready  = cnt_r <= RES_CNT_W'(RES_FIFO_DEPTH - 2);
  assign out_valid = cnt_r != '0;
  assign out_res   = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign wr_ptr_p1 = wr_ptr_r + RES_PTR_W'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + RES_PTR_W'(push.num);
    rd_ptr_nxt = pop ? rd_ptr_r + RES_PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + RES_CNT_W'(push.num) - RES_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.num == 2'd2) begin
      mem_r[wr_ptr_p1] <= push.r1;
    end
  end

endmodule

// File: hdl/stpf_core.sv
// descriptor store, pointers, totals and the per-operation decision logic
// depends on stpf_pkg
module stpf_core
  import stpf_pkg::*;
#(
  parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF,
  parameter int ENTRY_OVERHEAD = ENTRY_OVERHEAD_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  accept,
  input  req_t  req,
  output push_t push
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  entry_t         mem_r [QUEUE_DEPTH];
  entry_t         head_q_r;
  logic [PW-1:0]  head_r, head_nxt;
  logic [PW-1:0]  tail_r, tail_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [30:0]    bytes_r, bytes_nxt;
  logic [37:0]    time_r, time_nxt;
  logic [31:0]    epoch_r, epoch_nxt;
  logic           halted_r, halted_nxt;
  logic           wait_r, wait_nxt;

  entry_t         new_entry;
  logic           enq_req, enq_ok, get_ok, release_get, halted_eff, full;
  logic [30:0]    add_bytes, head_bytes;
  result_t        r0, r1;
  logic [1:0]     num;

  function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
    next_ptr = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_comb begin
    enq_req    = (req.opcode == OP_PUT) || (req.opcode == OP_MARKER) ||
                 (req.opcode == OP_START);
    halted_eff = (req.opcode == OP_START) ? 1'b0 : halted_r;
    full       = count_r >= CW'(QUEUE_DEPTH);
    enq_ok     = enq_req && !halted_eff && !full;
    release_get = enq_ok && wait_r;
    get_ok     = (req.opcode == OP_GET) && !halted_r && (count_r != '0);

    new_entry.marker   = req.opcode != OP_PUT;
    new_entry.handle   = new_entry.marker ? 64'd0 : req.descriptor;
    new_entry.size     = new_entry.marker ? 24'd0 : req.packet_size;
    new_entry.duration = new_entry.marker ? 32'd0 : req.packet_duration;
    new_entry.stream   = new_entry.marker ? 8'd0 : req.stream_id;
    new_entry.epoch    = epoch_r + 32'(new_entry.marker);

    add_bytes  = 31'(new_entry.size) + 31'(ENTRY_OVERHEAD);
    head_bytes = 31'(head_q_r.size) + 31'(ENTRY_OVERHEAD);

    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    bytes_nxt  = bytes_r;
    time_nxt   = time_r;
    epoch_nxt  = epoch_r;
    halted_nxt = halted_r;
    wait_nxt   = wait_r;

    if (accept) begin
      if (enq_ok) begin
        tail_nxt  = next_ptr(tail_r);
        epoch_nxt = new_entry.epoch;
        if (release_get) begin
          head_nxt = next_ptr(head_r);
          wait_nxt = 1'b0;
        end else begin
          count_nxt = count_r + CW'(1);
          bytes_nxt = bytes_r + add_bytes;
          time_nxt  = time_r + 38'(new_entry.duration);
        end
      end
      if (get_ok) begin
        head_nxt  = next_ptr(head_r);
        count_nxt = count_r - CW'(1);
        bytes_nxt = bytes_r - head_bytes;
        time_nxt  = time_r - 38'(head_q_r.duration);
      end
      if ((req.opcode == OP_GET) && !halted_r && (count_r == '0) &&
          req.wait_if_empty && !wait_r) begin
        wait_nxt = 1'b1;
      end
      if (req.opcode == OP_CLEAR) begin
        head_nxt  = '0;
        tail_nxt  = '0;
        count_nxt = '0;
        bytes_nxt = '0;
        time_nxt  = '0;
      end
      if (req.opcode == OP_ABORT) begin
        halted_nxt = 1'b1;
        wait_nxt   = 1'b0;
      end
      if (req.opcode == OP_START) begin
        halted_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    r0        = '0;
    r1        = '0;
    r0.count  = 7'(count_nxt);
    r0.bytes  = bytes_nxt;
    r0.qtime  = time_nxt;
    r1.count  = 7'(count_nxt);
    r1.bytes  = bytes_nxt;
    r1.qtime  = time_nxt;
    r0.kind   = KIND_CTRL;
    r0.status = ST_OK;
    r1.kind   = KIND_GET;
    r1.status = ST_OK;
    num       = 2'd1;
    unique case (req.opcode)
      OP_PUT, OP_MARKER, OP_START: begin
        r0.kind = (req.opcode == OP_START) ? KIND_CTRL : KIND_PUT;
        if (halted_eff) begin
          r0.status = ST_ABORTED;
        end else if (full) begin
          r0.status = ST_FULL;
        end
        if (release_get) begin
          num           = 2'd2;
          r1.descriptor = new_entry.handle;
          r1.size       = new_entry.size;
          r1.duration   = new_entry.duration;
          r1.stream     = new_entry.stream;
          r1.is_flush   = new_entry.marker;
          r1.serial     = new_entry.epoch;
        end
      end
      OP_GET: begin
        r0.kind = KIND_GET;
        if (halted_r) begin
          r0.status = ST_ABORTED;
        end else if (get_ok) begin
          r0.descriptor = head_q_r.handle;
          r0.size       = head_q_r.size;
          r0.duration   = head_q_r.duration;
          r0.stream     = head_q_r.stream;
          r0.is_flush   = head_q_r.marker;
          r0.serial     = head_q_r.epoch;
        end else if (req.wait_if_empty && !wait_r) begin
          num = 2'd0;
        end else begin
          r0.status = ST_EMPTY;
        end
      end
      OP_ABORT: begin
        if (wait_r) begin
          num       = 2'd2;
          r1.status = ST_ABORTED;
        end
      end
      default: begin
      end
    endcase
    r0.last   = num == 2'd1;
    r1.last   = 1'b1;
    push.num  = accept ? num : 2'd0;
    push.r0   = r0;
    push.r1   = r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      tail_r   <= '0;
      count_r  <= '0;
      bytes_r  <= '0;
      time_r   <= '0;
      epoch_r  <= '0;
      halted_r <= 1'b1;
      wait_r   <= 1'b0;
    end else begin
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      count_r  <= count_nxt;
      bytes_r  <= bytes_nxt;
      time_r   <= time_nxt;
      epoch_r  <= epoch_nxt;
      halted_r <= halted_nxt;
      wait_r   <= wait_nxt;
    end
  end

  // store write at the tail, head entry kept registered with write bypass
  always_ff @(posedge clk) begin
    if (accept && enq_ok) begin
      mem_r[tail_r] <= new_entry;
    end
    if (accept && enq_ok && (tail_r == head_nxt)) begin
      head_q_r <= new_entry;
    end else begin
      head_q_r <= mem_r[head_nxt];
    end
  end

endmodule

// File: hdl/stpf_checker.sv
// port-level checks of the packet descriptor queue and their bind
// depends on stpf_pkg and serial_tagged_packet_fifo_defines.svh
`include "serial_tagged_packet_fifo_defines.svh"

module stpf_checker
  import stpf_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [OUT_USER_W-1:0] out_tuser,
  input logic                  out_tlast
);

  // a result held back by the receiver stays put
  `STPF_ASSERT_NEXT(a_stall_hold, clk, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), rst_n)

  // the second result of an operation is a get reply, ready right behind the first
  `STPF_ASSERT_NEXT(a_pair_follows, clk, out_tvalid && out_tready && !out_tlast, out_tvalid && (out_tuser == KIND_GET) && out_tlast, rst_n)

  // no result pending after reset
  `STPF_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_tvalid && in_tready)

  // every result carries a known reply kind
  `STPF_ASSERT_SAME(a_reply_kind, clk, rst_n, out_tvalid, (out_tuser == KIND_PUT) || (out_tuser == KIND_GET) || (out_tuser == KIND_CTRL))

endmodule

bind serial_tagged_packet_fifo stpf_checker u_stpf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
